// File: rtl/smca_pkg.sv
// ----------------------------------------------------------------------------
// smca_pkg
// Shared types, constants and helper functions of the strided core allocator.
// ----------------------------------------------------------------------------
package smca_pkg;

    localparam int MAX_CORES   = 64;
    localparam int CORE_W      = $clog2(MAX_CORES);
    localparam int COUNT_W     = 7;
    localparam int TAG_W       = 16;
    localparam int MASK_W      = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;

    typedef enum logic [1:0] {
        REG_CORE_COUNT   = 2'd0,
        REG_STRIDE       = 2'd1,
        REG_CORE_ENABLE  = 2'd2,
        REG_NONE         = 2'd3
    } smca_reg_idx_t;

    localparam logic [COUNT_W-1:0] CORE_COUNT_RST   = COUNT_W'(64);
    localparam logic [COUNT_W-1:0] STRIDE_RST       = COUNT_W'(1);
    localparam logic [MASK_W-1:0]  CORE_ENABLE_RST  = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ADVANCE,
        ST_EMIT
    } smca_state_t;

    typedef struct packed {
        logic load;
        logic search;
        logic advance;
        logic emit;
    } smca_cmd_t;

    typedef struct packed {
        logic search_done;
        logic adv_done;
    } smca_status_t;

    // index of the lowest set bit, zero when none is set
    function automatic logic [CORE_W-1:0] lowest_set(input logic [MASK_W-1:0] vec);
        logic [CORE_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = CORE_W'(i);
            end
        end
        return idx;
    endfunction

    // one strided step; c < n and 1 <= s <= n hold on entry
    function automatic logic [CORE_W-1:0] step_core(
        input logic [CORE_W-1:0]  c,
        input logic [COUNT_W-1:0] n,
        input logic [COUNT_W-1:0] s
    );
        logic [COUNT_W-1:0] sum;
        logic [COUNT_W-1:0] wrapped;
        logic [CORE_W-1:0]  res;
        sum = {1'b0, c} + s;
        if (sum >= n)
        begin
            wrapped = sum - n + COUNT_W'(1);
            res     = (wrapped == s) ? '0 : wrapped[CORE_W-1:0];
        end
        else
        begin
            res = sum[CORE_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/smca_ifs.sv
// ----------------------------------------------------------------------------
// smca_ifs
// Valid/ready channels for placement requests and placement results.
// ----------------------------------------------------------------------------
interface smca_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] thread_tag;
    logic [63:0] busy_cores;

    modport source (output valid, output thread_tag, output busy_cores, input ready);
    modport sink   (input valid, input thread_tag, input busy_cores, output ready);
endinterface

interface smca_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] placed_thread;
    logic [5:0]  assigned_core;
    logic        none_free;

    modport source (output valid, output placed_thread, output assigned_core,
                    output none_free, input ready);
    modport sink   (input valid, input placed_thread, input assigned_core,
                    input none_free, output ready);
endinterface

// File: rtl/smca_cfg_regs.sv
// ----------------------------------------------------------------------------
// smca_cfg_regs
// APB register file: core count, stride and core enable mask.
// ----------------------------------------------------------------------------
module smca_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [smca_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [smca_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [smca_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [smca_pkg::COUNT_W-1:0]     core_count,
    output logic [smca_pkg::COUNT_W-1:0]     stride,
    output logic [smca_pkg::MASK_W-1:0]      core_enable,
    output logic                             cfg_wr
);
    import smca_pkg::*;

    logic [COUNT_W-1:0] core_count_reg;
    logic [COUNT_W-1:0] stride_reg;
    logic [MASK_W-1:0]  core_enable_reg;
    smca_reg_idx_t      idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = smca_reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg_wr = wr_en && (idx != REG_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_count_reg   <= CORE_COUNT_RST;
            stride_reg       <= STRIDE_RST;
            core_enable_reg  <= CORE_ENABLE_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CORE_COUNT:   core_count_reg   <= pwdata[COUNT_W-1:0];
                REG_STRIDE:       stride_reg       <= pwdata[COUNT_W-1:0];
                REG_CORE_ENABLE:  core_enable_reg  <= pwdata[MASK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CORE_COUNT:   prdata = CFG_DATA_W'(core_count_reg);
            REG_STRIDE:       prdata = CFG_DATA_W'(stride_reg);
            REG_CORE_ENABLE:  prdata = CFG_DATA_W'(core_enable_reg);
            default:          prdata = '0;
        endcase
    end

    assign core_count   = core_count_reg;
    assign stride       = stride_reg;
    assign core_enable  = core_enable_reg;

endmodule

// File: rtl/smca_ctrl.sv
// ----------------------------------------------------------------------------
// smca_ctrl
// Sequencer: accept, strided search, pointer advance, result hand-off.
// ----------------------------------------------------------------------------
module smca_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  smca_pkg::smca_status_t  status,
    output smca_pkg::smca_cmd_t     cmd
);
    import smca_pkg::*;

    smca_state_t state_reg;
    smca_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.search_done)
                begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE:
            begin
                if (status.adv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SEARCH:  cmd.search  = 1'b1;
            ST_ADVANCE: cmd.advance = 1'b1;
            ST_EMIT:    cmd.emit    = out_free;
            default:    ;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_search_to_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && status.search_done) |=> state_reg == ST_ADVANCE)
        else $error("search end did not start pointer advance");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending result dropped");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_SEARCH)
        else $error("accepted request did not start a search");

endmodule

// File: rtl/smca_dp.sv
// ----------------------------------------------------------------------------
// smca_dp
// Datapath: request latch, strided walker, start pointer and result register.
// ----------------------------------------------------------------------------
module smca_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smca_pkg::smca_cmd_t           cmd,
    output smca_pkg::smca_status_t        status,
    input  logic [smca_pkg::TAG_W-1:0]    thread_tag,
    input  logic [smca_pkg::MASK_W-1:0]   busy_cores,
    input  logic [smca_pkg::COUNT_W-1:0]  core_count,
    input  logic [smca_pkg::COUNT_W-1:0]  stride,
    input  logic [smca_pkg::MASK_W-1:0]   core_enable,
    input  logic                          cfg_wr,
    output logic [smca_pkg::TAG_W-1:0]    placed_thread,
    output logic [smca_pkg::CORE_W-1:0]   assigned_core,
    output logic                          none_free
);
    import smca_pkg::*;

    logic [COUNT_W-1:0] n_cores;
    logic [COUNT_W-1:0] s_eff;
    logic [MASK_W-1:0]  n_mask;
    logic [CORE_W-1:0]  start_value;

    logic [TAG_W-1:0]   tag_reg;
    logic [MASK_W-1:0]  busy_reg;
    logic [CORE_W-1:0]  start_reg;
    logic [CORE_W-1:0]  cur_reg;
    logic [CORE_W-1:0]  cnt_reg;
    logic [CORE_W-1:0]  chosen_reg;
    logic               flag_reg;
    logic [CORE_W-1:0]  next_start_reg;
    logic               use_lowest_reg;
    logic [TAG_W-1:0]   placed_thread_reg;
    logic [CORE_W-1:0]  assigned_core_reg;
    logic               none_free_reg;

    logic               en_cur;
    logic               wrap_hit;
    logic               free_hit;
    logic               last_pos;
    logic [CORE_W-1:0]  chosen_sel;
    logic [CORE_W-1:0]  cur_step;
    logic               adv_hit;

    always_comb
    begin
        if (core_count == '0)
        begin
            n_cores = COUNT_W'(1);
        end
        else if (core_count > COUNT_W'(MAX_CORES))
        begin
            n_cores = COUNT_W'(MAX_CORES);
        end
        else
        begin
            n_cores = core_count;
        end

        if (stride == '0)
        begin
            s_eff = COUNT_W'(1);
        end
        else if (stride > n_cores)
        begin
            s_eff = n_cores;
        end
        else
        begin
            s_eff = stride;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            n_mask[i] = (COUNT_W'(i) < n_cores);
        end
    end

    assign start_value = use_lowest_reg ? lowest_set(core_enable & n_mask) : next_start_reg;

    assign cur_step   = step_core(cur_reg, n_cores, s_eff);
    assign last_pos   = (cnt_reg == CORE_W'(MAX_CORES - 1));
    assign en_cur     = core_enable[cur_reg];
    assign wrap_hit   = (cnt_reg != '0) && (cur_reg == start_reg) && en_cur;
    assign free_hit   = !wrap_hit && en_cur && !busy_reg[cur_reg];
    assign chosen_sel = free_hit ? cur_reg : start_reg;
    assign adv_hit    = core_enable[cur_step];

    assign status.search_done = wrap_hit || free_hit || last_pos;
    assign status.adv_done    = adv_hit || last_pos;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg   <= thread_tag;
            busy_reg  <= busy_cores;
            start_reg <= start_value;
            cur_reg   <= start_value;
            cnt_reg   <= '0;
        end
        else if (cmd.search)
        begin
            if (status.search_done)
            begin
                chosen_reg <= chosen_sel;
                flag_reg   <= !free_hit;
                cur_reg    <= chosen_sel;
                cnt_reg    <= '0;
            end
            else
            begin
                cur_reg <= cur_step;
                cnt_reg <= cnt_reg + CORE_W'(1);
            end
        end
        else if (cmd.advance)
        begin
            if (status.adv_done)
            begin
                next_start_reg <= adv_hit ? cur_step : chosen_reg;
            end
            else
            begin
                cur_reg <= cur_step;
                cnt_reg <= cnt_reg + CORE_W'(1);
            end
        end

        if (cmd.emit)
        begin
            placed_thread_reg <= tag_reg;
            assigned_core_reg <= chosen_reg;
            none_free_reg     <= flag_reg;
        end
    end

    // pointer falls back to the lowest enabled core after reset or a write to a mapped register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_lowest_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            use_lowest_reg <= 1'b1;
        end
        else if (cmd.advance && status.adv_done)
        begin
            use_lowest_reg <= 1'b0;
        end
    end

    assign placed_thread = placed_thread_reg;
    assign assigned_core = assigned_core_reg;
    assign none_free     = none_free_reg;

    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.search || cmd.advance) |-> ({1'b0, cur_reg} < n_cores))
        else $error("walk position beyond core count");

    a_found_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.search && free_hit) |=> (!flag_reg && core_enable[chosen_reg]
                                      && !busy_reg[chosen_reg]))
        else $error("chosen core not enabled and idle");

    a_pointer_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.advance && adv_hit) |=> core_enable[next_start_reg])
        else $error("pointer advanced to a disabled core");

endmodule

// File: rtl/strided_masked_core_allocator.sv
// Sequence: a transferred request starts a strided search over 1..64 walk positions, then
//   a pointer advance of 1..64 steps to the next enabled core; the result is registered
//   once the result register is free and is held there while it waits on ready.
// Throughput: one request at a time; the next transfer is taken only after the previous
//   result is in the result register, one core examined per cycle by the walker.
// Reset (rst_n, async low): 64 cores, stride 1, all cores enabled; pointer at lowest.
// ----------------------------------------------------------------------------
// strided_masked_core_allocator
// Places each thread on the first enabled idle core of a strided walk.
// ----------------------------------------------------------------------------
module strided_masked_core_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    smca_req_if.sink                         req,
    smca_res_if.source                       res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [smca_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [smca_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [smca_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import smca_pkg::*;

    logic [COUNT_W-1:0] core_count;
    logic [COUNT_W-1:0] stride;
    logic [MASK_W-1:0]  core_enable;
    logic               cfg_wr;
    smca_cmd_t          cmd;
    smca_status_t       status;

    smca_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .core_count   (core_count),
        .stride       (stride),
        .core_enable  (core_enable),
        .cfg_wr       (cfg_wr)
    );

    smca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    smca_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .thread_tag    (req.thread_tag),
        .busy_cores    (req.busy_cores),
        .core_count    (core_count),
        .stride        (stride),
        .core_enable   (core_enable),
        .cfg_wr        (cfg_wr),
        .placed_thread (res.placed_thread),
        .assigned_core (res.assigned_core),
        .none_free     (res.none_free)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strided masked core allocator. A driver and a
// monitor stand on the request and result channels; the registers are set
// over the APB-style port while the block is idle. Every request transfer is
// run through a bench-side copy of the strided walk, and each result transfer
// is compared field by field with the oldest expected placement.
// ----------------------------------------------------------------------------
module tb_top;
    import smca_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 60;
    localparam int DRAIN_CYCLES   = 150;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 50;

    typedef struct {
        logic [TAG_W-1:0]  tag;
        logic [MASK_W-1:0] busy;
    } place_req_t;

    typedef struct {
        logic [TAG_W-1:0]  thread;
        logic [CORE_W-1:0] core;
        logic              none_free;
    } placement_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    smca_req_if req_ch ();
    smca_res_if res_ch ();

    strided_masked_core_allocator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // allocator shadow state
    logic [COUNT_W-1:0] cfg_active;
    logic [COUNT_W-1:0] cfg_stride;
    logic [MASK_W-1:0]  cfg_enable;
    logic [CORE_W-1:0]  next_start;

    place_req_t req_q[$];
    placement_t placement_q[$];
    place_req_t cur_req;

    int  n_queued;
    int  n_results;
    int  n_errors;
    int  n_settings;
    int  n_no_free;
    int  idle_pct;
    bit  src_pause;
    int  hold_left;
    bit  hold_done;
    int  stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int core_count();
        int n;
        n = int'(cfg_active);
        if (n < 1) n = 1;
        if (n > MAX_CORES) n = MAX_CORES;
        return n;
    endfunction

    function automatic int walk_stride(input int n);
        int s;
        s = int'(cfg_stride);
        if (s < 1) s = 1;
        if (s > n) s = n;
        return s;
    endfunction

    function automatic bit core_on(input logic [MASK_W-1:0] mask, input int c, input int n);
        return (c < n) && mask[c];
    endfunction

    function automatic int walk_step(input int c, input int n, input int s);
        int r;
        r = c + s;
        if (r >= n)
        begin
            r = ((r % n) + 1) % s;
        end
        return r;
    endfunction

    function automatic int lowest_enabled_core();
        int n;
        n = core_count();
        for (int c = 0; c < n; c++)
        begin
            if (core_on(cfg_enable, c, n))
            begin
                return c;
            end
        end
        return 0;
    endfunction

    function automatic int next_enabled_core(input int from, input int n, input int s);
        int c;
        c = from;
        for (int k = 0; k < MAX_CORES; k++)
        begin
            c = walk_step(c, n, s);
            if (core_on(cfg_enable, c, n))
            begin
                return c;
            end
        end
        return from;
    endfunction

    function automatic placement_t place_thread(input place_req_t rq);
        int         n;
        int         s;
        int         start;
        int         c;
        int         chosen;
        logic       flag;
        placement_t p;
        n      = core_count();
        s      = walk_stride(n);
        start  = int'(next_start) % n;
        c      = start;
        chosen = start;
        flag   = 1'b1;
        for (int k = 0; k < MAX_CORES; k++)
        begin
            if (k > 0 && c == start && core_on(cfg_enable, c, n))
            begin
                break;
            end
            if (core_on(cfg_enable, c, n) && !core_on(rq.busy, c, n))
            begin
                chosen = c;
                flag   = 1'b0;
                break;
            end
            c = walk_step(c, n, s);
        end
        next_start  = CORE_W'(next_enabled_core(chosen, n, s));
        p.thread    = rq.tag;
        p.core      = CORE_W'(chosen);
        p.none_free = flag;
        if (flag)
        begin
            n_no_free++;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        n_errors++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                cur_req.tag  = req_ch.thread_tag;
                cur_req.busy = req_ch.busy_cores;
                placement_q.insert(placement_q.size(), place_thread(cur_req));
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_q.size() > 0 && !src_pause && $urandom_range(99) >= idle_pct)
                begin
                    cur_req = req_q.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.thread_tag <= cur_req.tag;
                    req_ch.busy_cores <= cur_req.busy;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor, with one long hold-off on ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                n_results++;
                if (placement_q.size() == 0)
                begin
                    report_mismatch("unexpected result, core", res_ch.assigned_core, 0);
                end
                else
                begin
                    placement_t want;
                    want = placement_q.pop_front();
                    if (res_ch.placed_thread !== want.thread)
                        report_mismatch("placed_thread", res_ch.placed_thread, want.thread);
                    if (res_ch.assigned_core !== want.core)
                        report_mismatch("assigned_core", res_ch.assigned_core, want.core);
                    if (res_ch.none_free !== want.none_free)
                        report_mismatch("none_free", res_ch.none_free, want.none_free);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!hold_done && n_results >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // watchdog: cycles with work outstanding and no transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
                || n_queued == n_results)
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", stall_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic queue_request(input logic [TAG_W-1:0] tag, input logic [MASK_W-1:0] busy);
        place_req_t rq;
        rq.tag  = tag;
        rq.busy = busy;
        req_q.insert(req_q.size(), rq);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_results != n_queued)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic apb_write(input smca_reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(int'(idx) * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CORE_COUNT:   cfg_active = value[COUNT_W-1:0];
            REG_STRIDE:       cfg_stride = value[COUNT_W-1:0];
            REG_CORE_ENABLE:  cfg_enable = value[MASK_W-1:0];
            default:          ;
        endcase
        if (idx != REG_NONE)
        begin
            next_start = CORE_W'(lowest_enabled_core());
        end
    endtask

    task automatic set_config(input int active, input int stride,
                              input logic [MASK_W-1:0] enable, input bit junk);
        logic [CFG_DATA_W-1:0] w;
        w = junk ? {$urandom, $urandom} : '0;
        w[COUNT_W-1:0] = COUNT_W'(active);
        apb_write(REG_CORE_COUNT, w);
        w = junk ? {$urandom, $urandom} : '0;
        w[COUNT_W-1:0] = COUNT_W'(stride);
        apb_write(REG_STRIDE, w);
        apb_write(REG_CORE_ENABLE, enable);
        n_settings++;
    endtask

    function automatic logic [MASK_W-1:0] random_busy();
        logic [MASK_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(7))
            0:       return '1;
            1:       return '0;
            2:       return r;
            3:       return ~(64'd1 << $urandom_range(63));
            4:       return r | {$urandom, $urandom} | {$urandom, $urandom};
            default: return r | {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] random_enable();
        logic [MASK_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(4))
            0:       return '1;
            1:       return r | (64'd1 << $urandom_range(63));
            2:       return (r & {$urandom, $urandom}) | (64'd1 << $urandom_range(63));
            3:       return 64'd1 << $urandom_range(63);
            default: return ~(r & {$urandom, $urandom} & {$urandom, $urandom});
        endcase
    endfunction

    initial
    begin
        int active;
        int stride;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.thread_tag = '0;
        req_ch.busy_cores = '0;
        res_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        n_queued          = 0;
        n_results         = 0;
        n_errors          = 0;
        n_settings        = 1;
        n_no_free         = 0;
        idle_pct          = 35;
        src_pause         = 1'b0;
        hold_left         = 0;
        hold_done         = 1'b0;
        stall_cycles      = 0;
        cfg_active        = CORE_COUNT_RST;
        cfg_stride        = STRIDE_RST;
        cfg_enable        = CORE_ENABLE_RST;
        next_start        = CORE_W'(lowest_enabled_core());
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: free, full, last-core-only, alternating, first-core-only
        queue_request(16'h0000, 64'h0);
        queue_request(16'hFFFF, '1);
        queue_request(16'h8001, ~(64'd1 << 63));
        queue_request(16'h1234, 64'h5555_5555_5555_5555);
        queue_request(16'h4321, ~64'd1);
        wait_drained();

        // write to an unmapped register keeps the pointer
        apb_write(REG_NONE, 64'h2A);
        queue_request(16'h00A5, 64'h0);
        wait_drained();

        // single core; busy bits beyond the count are ignored
        set_config(1, 1, '1, 1'b0);
        queue_request(16'h0001, 64'h0);
        queue_request(16'h0002, 64'h1);
        queue_request(16'h0003, ~64'h1);
        wait_drained();

        // zero count and zero stride saturate up
        set_config(0, 0, '1, 1'b0);
        queue_request(16'h0004, '1);
        queue_request(16'h0005, 64'h0);
        wait_drained();

        // count above the maximum, stride equal to the count
        set_config(100, 64, '1, 1'b0);
        queue_request(16'h0006, {$urandom, $urandom});
        queue_request(16'h0007, ~(64'd1 << 63));
        queue_request(16'h0008, '1);
        wait_drained();

        // stride above the count; enables only beyond the count
        set_config(10, 20, ~64'h3FF, 1'b0);
        queue_request(16'h0009, 64'h0);
        queue_request(16'h000A, '1);
        wait_drained();

        // one enabled core: next pointer stays on it
        set_config(12, 5, 64'h80, 1'b0);
        queue_request(16'h000B, 64'h0);
        queue_request(16'h000C, 64'h0);
        queue_request(16'h000D, 64'h80);
        wait_drained();

        // stride below the count, all busy
        set_config(10, 4, '1, 1'b0);
        queue_request(16'h000E, '1);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case ($urandom_range(3))
                0:       active = MAX_CORES;
                1:       active = $urandom_range(1, 4);
                default: active = $urandom_range(1, MAX_CORES);
            endcase
            case ($urandom_range(7))
                0:       stride = active;
                1:       stride = $urandom_range(active, 127);
                2:       stride = 1;
                default: stride = $urandom_range(1, active);
            endcase
            if (p == 0)
            begin
                active = MAX_CORES;
                stride = 1;
            end
            set_config(active, stride, random_enable(), 1'b1);
            if (p == 2)
            begin
                idle_pct = 0;
            end
            if (p == 5)
            begin
                for (int i = 0; i < PHASE_ITEMS / 2; i++)
                begin
                    queue_request(16'($urandom), random_busy());
                end
                while (req_q.size() > PHASE_ITEMS / 4)
                begin
                    @(posedge clk);
                end
                src_pause = 1'b1;
                @(posedge clk);
                while (req_ch.valid || placement_q.size() != 0)
                begin
                    @(posedge clk);
                end
                src_pause = 1'b0;
                for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++)
                begin
                    queue_request(16'($urandom), random_busy());
                end
            end
            else
            begin
                for (int i = 0; i < PHASE_ITEMS; i++)
                begin
                    queue_request(16'($urandom), random_busy());
                end
            end
            wait_drained();
            idle_pct = 35;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (placement_q.size() != 0)
        begin
            report_mismatch("results still missing", 0, placement_q.size());
        end

        $display("Placed %0d threads across %0d register settings.", n_results, n_settings);
        $display("%0d placements found no enabled idle core.", n_no_free);
        if (n_errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
